// ----- rtl/lstp_pkg.sv -----
// Shared constants, types and helpers for the lidar scan to points block.
`timescale 1ns / 1ps
`default_nettype none

package lstp_pkg;

  // Beam table geometry
  localparam int BEAMS          = 1024;
  localparam int ADDR_W         = $clog2(BEAMS);
  localparam int BEAM_W         = 10;

  // Fixed-point formats
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W         = 16;
  localparam int DIR_W          = 16;
  localparam int RANGE_W        = 16;
  localparam int TRANS_W        = 16;
  localparam int DIRS_W         = 3 * DIR_W;
  localparam int ROW_W          = 3 * COEF_W;
  localparam int SCALED_W       = DIR_W + RANGE_W + 1;
  localparam int PROD_W         = COEF_W + SCALED_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int SHIFT          = 2 * COEF_FRAC_BITS;
  localparam int PT_W           = 20;

  // Stream payload layout, lowest bit first
  localparam int IN_BEAM_LSB    = 0;
  localparam int IN_RANGE_LSB   = IN_BEAM_LSB + BEAM_W;
  localparam int IN_DIRS_LSB    = IN_RANGE_LSB + RANGE_W;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 72;

  // Configuration register indexes
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE  = 3'd0,
    REG_MAX_RANGE  = 3'd1,
    REG_FIRST_BEAM = 3'd2,
    REG_LAST_BEAM  = 3'd3,
    REG_ROT_ROW0   = 3'd4,
    REG_ROT_ROW1   = 3'd5,
    REG_ROT_ROW2   = 3'd6,
    REG_TRANSLATE  = 3'd7
  } lstp_reg_t;

  // Request kinds carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Rotation matrix and translation as seen by the transform pipeline
  typedef struct packed {
    coef_t [2:0][2:0] rot;
    coef_t [2:0]      trans;
  } lstp_geom_t;

  // Sideband that travels with a kept sample
  typedef struct packed {
    logic [BEAM_W-1:0] beam;
    logic              last;
  } lstp_tag_t;

  // Clamp a wide signed value to the point range
  function automatic logic [PT_W-1:0] sat_point(input logic signed [SUM_W:0] v);
    logic upper_ones;
    logic upper_zeros;
    upper_ones  = &v[SUM_W:PT_W-1];
    upper_zeros = ~|v[SUM_W:PT_W-1];
    if (upper_ones || upper_zeros) begin
      sat_point = v[PT_W-1:0];
    end else if (v[SUM_W]) begin
      sat_point = {1'b1, {(PT_W-1){1'b0}}};
    end else begin
      sat_point = {1'b0, {(PT_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lstp_dir_ram.sv -----
// Simple dual-port RAM holding beam directions, with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module lstp_dir_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lstp_xform.sv -----
// Transform pipeline: scale by range, rotate, round, translate, saturate.
`timescale 1ns / 1ps
`default_nettype none

module lstp_xform
  import lstp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DIRS_W-1:0]     in_dirs,
  input  wire logic [RANGE_W-1:0]    in_range,
  input  wire lstp_tag_t             in_tag,
  input  wire lstp_geom_t            geom,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PT_W-1:0]            out_x,
  output logic [PT_W-1:0]            out_y,
  output logic [PT_W-1:0]            out_z,
  output lstp_tag_t                  out_tag
);

  logic                       v2, v3, v4;
  logic                       en2, en3, en4, en_out;
  logic signed [SCALED_W-1:0] scaled [3];
  logic signed [PROD_W-1:0]   prod [3][3];
  logic signed [SUM_W-1:0]    acc [3];
  lstp_tag_t                  tag2, tag3, tag4;
  logic signed [SUM_W:0]      point [3];

  // Each stage advances when empty or when its successor advances
  assign en_out   = !out_valid || out_ready;
  assign en4      = !v4 || en_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign in_ready = en2;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) v2 <= in_valid;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  // Scale each direction component by the range
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int c = 0; c < 3; c++) begin
        scaled[c] <= SCALED_W'($signed(in_dirs[c*DIR_W +: DIR_W]))
                   * SCALED_W'($signed({1'b0, in_range}));
      end
      tag2 <= in_tag;
    end
  end

  // Multiply by every rotation coefficient
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          prod[i][c] <= PROD_W'(geom.rot[i][c]) * PROD_W'(scaled[c]);
        end
      end
      tag3 <= tag2;
    end
  end

  // Sum each row and add the rounding half
  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2])
                + (SUM_W'(1) <<< (SHIFT - 1));
      end
      tag4 <= tag3;
    end
  end

  // Drop the fraction and add the translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      point[i] = (SUM_W+1)'(acc[i] >>> SHIFT) + (SUM_W+1)'($signed(geom.trans[i]));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en_out && v4) begin
      out_x   <= sat_point(point[0]);
      out_y   <= sat_point(point[1]);
      out_z   <= sat_point(point[2]);
      out_tag <= tag4;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lidar_scan_to_points.sv -----
// Top level: configuration registers, sample filter, direction table, transform.
`timescale 1ns / 1ps
`default_nettype none

// Converts lidar range samples into transformed Cartesian points at one request
// per clock when not stalled. A load request (tuser = 1) writes a beam direction
// into a 1024-entry table held in a single-port-write, single-port-read RAM; a
// sample request (tuser = 0) is kept when its beam lies in first_beam..last_beam
// and its range is strictly between min_range and max_range, and gives one point.
// Throughput is one request per cycle when not stalled, set by the one RAM read
// per sample and a fully pipelined multiplier datapath. The direction table is not
// cleared by reset: every beam must be loaded before it is sampled. Rejected
// samples and loads produce nothing, and a rejected sample's tlast is lost.
// Configuration is to be written by the user through cfg_we/cfg_index/cfg_data
// only while no request is in flight; the block does not enforce this.

module lidar_scan_to_points
  import lstp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // beam_index[9:0], range_mm[25:10], dir_x[41:26], dir_y[57:42], dir_z[73:58]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  // Output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // point_x[19:0], point_y[39:20], point_z[59:40], source_beam[69:60]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  logic [RANGE_W-1:0] min_range, max_range;
  logic [BEAM_W-1:0]  first_beam, last_beam;
  logic [ROW_W-1:0]   rot_row0, rot_row1, rot_row2;
  logic [ROW_W-1:0]   translation;

  logic [BEAM_W-1:0]  in_beam;
  logic [RANGE_W-1:0] in_range;
  logic [DIRS_W-1:0]  in_dirs;
  logic               accept, in_table, keep, load;

  logic               v1, en1, xf_ready;
  logic [RANGE_W-1:0] range1;
  lstp_tag_t          tag1;
  logic [DIRS_W-1:0]  dirs1;
  lstp_geom_t         geom;
  logic               xf_valid;
  logic [PT_W-1:0]    pt_x, pt_y, pt_z;
  lstp_tag_t          out_tag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range   <= '0;
      max_range   <= '1;
      first_beam  <= '0;
      last_beam   <= '1;
      rot_row0    <= ROW_W'(1) << COEF_FRAC_BITS;
      rot_row1    <= ROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
      rot_row2    <= ROW_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);
      translation <= '0;
    end else if (cfg_we) begin
      case (lstp_reg_t'(cfg_index))
        REG_MIN_RANGE:  min_range   <= cfg_data[RANGE_W-1:0];
        REG_MAX_RANGE:  max_range   <= cfg_data[RANGE_W-1:0];
        REG_FIRST_BEAM: first_beam  <= cfg_data[BEAM_W-1:0];
        REG_LAST_BEAM:  last_beam   <= cfg_data[BEAM_W-1:0];
        REG_ROT_ROW0:   rot_row0    <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW1:   rot_row1    <= cfg_data[ROW_W-1:0];
        REG_ROT_ROW2:   rot_row2    <= cfg_data[ROW_W-1:0];
        REG_TRANSLATE:  translation <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom.rot[0] = rot_row0;
  assign geom.rot[1] = rot_row1;
  assign geom.rot[2] = rot_row2;
  assign geom.trans  = translation;

  // Unpack the request and decide what to do with it
  assign in_beam  = s_axis_tdata[IN_BEAM_LSB +: BEAM_W];
  assign in_range = s_axis_tdata[IN_RANGE_LSB +: RANGE_W];
  assign in_dirs  = s_axis_tdata[IN_DIRS_LSB +: DIRS_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_table = int'(in_beam) < BEAMS;
  assign load     = accept && (s_axis_tuser == CMD_LOAD) && in_table;
  assign keep     = accept && (s_axis_tuser == CMD_SAMPLE) && in_table
                 && (in_beam >= first_beam) && (in_beam <= last_beam)
                 && (in_range > min_range) && (in_range < max_range);

  // Table read stage advances when empty or when the transform takes it
  assign en1           = !v1 || xf_ready;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      range1    <= in_range;
      tag1.beam <= in_beam;
      tag1.last <= s_axis_tlast;
    end
  end

  // Direction table
  lstp_dir_ram #(
    .DEPTH (BEAMS),
    .WIDTH (DIRS_W)
  ) u_dir_ram (
    .clk   (clk),
    .we    (load),
    .waddr (ADDR_W'(in_beam)),
    .wdata (in_dirs),
    .re    (en1),
    .raddr (ADDR_W'(in_beam)),
    .rdata (dirs1)
  );

  lstp_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (xf_ready),
    .in_dirs   (dirs1),
    .in_range  (range1),
    .in_tag    (tag1),
    .geom      (geom),
    .out_valid (xf_valid),
    .out_ready (m_axis_tready),
    .out_x     (pt_x),
    .out_y     (pt_y),
    .out_z     (pt_z),
    .out_tag   (out_tag)
  );

  // Pack the result
  assign m_axis_tvalid = xf_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_tag.beam, pt_z, pt_y, pt_x});
  assign m_axis_tlast  = out_tag.last;

endmodule

`default_nettype wire

// ----- rtl/lstp_checker.sv -----
// Port-level checks for the lidar scan to points block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lstp_checker
  import lstp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tready,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  m_axis_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // No stall upstream when the output side can move
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output free");

  // Source beam always names a table entry
  a_beam_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> int'(m_axis_tdata[3*PT_W +: BEAM_W]) < BEAMS)
    else $error("source beam outside table");

endmodule

bind lidar_scan_to_points lstp_checker u_lstp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
